// File: sv/delayed_message_queue_core_defines.svh
// Assertion macros shared by the delayed message queue RTL
`ifndef DELAYED_MESSAGE_QUEUE_CORE_DEFINES_SVH
`define DELAYED_MESSAGE_QUEUE_CORE_DEFINES_SVH

// check a property on every clock outside reset
`define DMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define DMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dmq_pkg.sv
// Types, constants and helpers for the delayed message queue
package dmq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_ENQ     = 3'd0,
    KIND_POLL    = 3'd1,
    KIND_REM_OBJ = 3'd2,
    KIND_REM_CB  = 3'd3,
    KIND_REM_TOK = 3'd4,
    KIND_QUIT    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK   = 3'd0,
    STAT_NONE = 3'd1,
    STAT_NULL = 3'd2,
    STAT_QUIT = 3'd3,
    STAT_FULL = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_INS_WR,
    S_POP_CHK, S_DN_RD, S_DN_WR, S_PG_RD, S_PG_CHK, S_FINISH
  } state_e;

  typedef struct packed {
    logic [62:0] deadline;
    logic [15:0] target;
    logic [31:0] msg_id;
    logic [31:0] obj_key;
    logic [31:0] callback_key;
    logic [63:0] token;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  kind;
    logic [62:0] now;
    entry_t      ent;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    entry_t      ent;
    logic        wake_request;
    logic [62:0] wake_delay;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [62:0] due_delay(logic [62:0] due, logic [62:0] now);
    return (due <= now) ? 63'd0 : (due - now);
  endfunction

endpackage

// File: sv/dmq_ram.sv
// Generic one-write one-read RAM with registered read data
module dmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/dmq_ctrl.sv
// Sequencer that searches, shifts and compacts the sorted message table
`include "delayed_message_queue_core_defines.svh"
module dmq_ctrl
  import dmq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  cmd_t     cmd_i,
  input  entry_t   rdata_i,
  output mem_req_t mem_req_o,
  output logic     idle_o,
  output logic     done_o,
  output res_t     res_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             quit_q, quit_d;
  logic [62:0]      next_dl_q, next_dl_d;
  res_t             res_q, res_d;
  logic             hit;
  logic [62:0]      head_dl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      quit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      quit_q  <= quit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    wr_q      <= wr_d;
    pos_q     <= pos_d;
    next_dl_q <= next_dl_d;
    res_q     <= res_d;
  end

  always_comb begin
    hit = 1'b0;
    if (rdata_i.target == cmd_i.ent.target) begin
      case (cmd_i.kind)
        KIND_REM_OBJ: hit = (cmd_i.ent.obj_key == '0) ||
                            (rdata_i.obj_key == cmd_i.ent.obj_key);
        KIND_REM_CB:  hit = rdata_i.callback_key == cmd_i.ent.callback_key;
        default:      hit = rdata_i.token == cmd_i.ent.token;
      endcase
    end
    head_dl = (idx_q == CNT_W'(1)) ? rdata_i.deadline : next_dl_q;
  end

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    pos_d     = pos_q;
    quit_d    = quit_q;
    next_dl_d = next_dl_q;
    res_d     = res_q;
    mem_req_o = '0;
    done_o    = 1'b0;
    idle_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d   = '0;
        state_d = S_FINISH;
        case (cmd_i.kind)
          KIND_ENQ: begin
            if (cmd_i.ent.target == '0) begin
              res_d.status = STAT_NULL;
            end else if (quit_q) begin
              res_d.status = STAT_QUIT;
            end else if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
              res_d.status = STAT_FULL;
            end else if (occ_q == '0 || cmd_i.ent.deadline == '0) begin
              pos_d   = '0;
              idx_d   = occ_q;
              state_d = (occ_q == '0) ? S_INS_WR : S_SH_RD;
            end else begin
              idx_d   = '0;
              state_d = S_SCAN_RD;
            end
          end
          KIND_POLL: begin
            if (quit_q) begin
              res_d.status = STAT_QUIT;
            end else if (occ_q == '0) begin
              res_d.status = STAT_NONE;
            end else begin
              mem_req_o.raddr = '0;
              state_d = S_POP_CHK;
            end
          end
          KIND_REM_OBJ, KIND_REM_CB, KIND_REM_TOK: begin
            if (!((cmd_i.kind == KIND_REM_CB && cmd_i.ent.callback_key == '0) ||
                  (cmd_i.kind == KIND_REM_TOK && cmd_i.ent.token == '0) ||
                  occ_q == '0)) begin
              idx_d   = '0;
              wr_d    = '0;
              state_d = S_PG_RD;
            end
          end
          KIND_QUIT: begin
            quit_d             = 1'b1;
            res_d.wake_request = 1'b1;
          end
          default: ;
        endcase
      end
      S_SCAN_RD: begin
        mem_req_o.raddr = idx_q[IDX_W-1:0];
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata_i.deadline <= cmd_i.ent.deadline) begin
          if (idx_q + CNT_W'(1) < occ_q) begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_SCAN_RD;
          end else begin
            pos_d   = occ_q;
            state_d = S_INS_WR;
          end
        end else begin
          pos_d   = idx_q;
          idx_d   = occ_q;
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: begin
        mem_req_o.raddr = 
          IDX_W'(idx_q - CNT_W'(1));
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q[IDX_W-1:0];
        mem_req_o.wdata = rdata_i;
        idx_d   = idx_q - CNT_W'(1);
        state_d = (idx_q - CNT_W'(1) == pos_q) ? S_INS_WR : S_SH_RD;
      end
      S_INS_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q[IDX_W-1:0];
        mem_req_o.wdata = cmd_i.ent;
        occ_d = occ_q + CNT_W'(1);
        if (pos_q == '0) begin
          res_d.wake_request = 1'b1;
          res_d.wake_delay   = due_delay(cmd_i.ent.deadline, cmd_i.now);
        end
        state_d = S_FINISH;
      end
      S_POP_CHK: begin
        if (cmd_i.now >= rdata_i.deadline) begin
          res_d.ent = rdata_i;
          idx_d     = CNT_W'(1);
          if (occ_q == CNT_W'(1)) begin
            occ_d   = '0;
            state_d = S_FINISH;
          end else begin
            state_d = S_DN_RD;
          end
        end else begin
          res_d.status       = STAT_NONE;
          res_d.wake_request = 1'b1;
          res_d.wake_delay   = rdata_i.deadline - cmd_i.now;
          state_d            = S_FINISH;
        end
      end
      S_DN_RD: begin
        mem_req_o.raddr = idx_q[IDX_W-1:0];
        state_d = S_DN_WR;
      end
      S_DN_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IDX_W'(idx_q - CNT_W'(1));
        mem_req_o.wdata = rdata_i;
        next_dl_d = head_dl;
        if (idx_q + CNT_W'(1) == occ_q) begin
          occ_d              = occ_q - CNT_W'(1);
          res_d.wake_request = 1'b1;
          res_d.wake_delay   = due_delay(head_dl, cmd_i.now);
          state_d            = S_FINISH;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_DN_RD;
        end
      end
      S_PG_RD: begin
        mem_req_o.raddr = idx_q[IDX_W-1:0];
        state_d = S_PG_CHK;
      end
      S_PG_CHK: begin
        if (!hit) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = wr_q[IDX_W-1:0];
          mem_req_o.wdata = rdata_i;
          wr_d = wr_q + CNT_W'(1);
        end
        if (idx_q + CNT_W'(1) == occ_q) begin
          occ_d   = wr_q + {{(CNT_W-1){1'b0}}, ~hit};
          state_d = S_FINISH;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_PG_RD;
        end
      end
      S_FINISH: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o = res_q;

  `DMQ_ASSERT(a_occ_bound, occ_q <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
  `DMQ_ASSERT(a_no_wr_idle, (state_q == S_IDLE) |-> !mem_req_o.we, "write while idle")
  `DMQ_ASSERT_NEXT(a_done_idle, done_o, state_q == S_IDLE, "no return to idle after done")
  `DMQ_ASSERT_NEXT(a_quit_sticky, quit_q, quit_q, "quit flag cleared")

endmodule

// File: sv/delayed_message_queue_core.sv
// Top level of the delayed message queue: stream ports, command and result registers
//
// Usage: one command per transfer on the slave stream (tuser = kind), exactly one
// result per command on the master stream (tuser = status and wake request).
// Commands: enqueue, poll, remove by object/callback/token, quit.
// Entries live in a single RAM of QUEUE_DEPTH rows kept sorted by due time; the
// sequencer moves rows through its one read and one write port. Enqueue scans rows
// for the insert position, then shifts the later rows up; poll delivers the due
// head and moves the remaining rows down; removal reads every row and compacts.
// One command is in flight at a time; the next is taken once the result has been
// transferred.
// Reset empties the table and clears quit; RAM contents need no clearing since only
// rows below the occupancy are read.
// A stalled receiver holds the result in the output register and tready stays low.
`include "delayed_message_queue_core_defines.svh"
module delayed_message_queue_core
  import dmq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // now, deadline, msg_id, target, obj_key, callback_key, token, zero pad
  input  logic [303:0] s_axis_tdata_i,
  // kind
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_msg_id, out_target, out_obj_key, out_callback_key, out_token,
  // out_deadline, wake_delay, zero pad
  output logic [303:0] m_axis_tdata_o,
  // status, wake_request
  output logic [3:0]   m_axis_tuser_o
);

  cmd_t     cmd_q;
  logic     m_valid_q;
  logic     idle;
  logic     done;
  logic     accept;
  res_t     res;
  mem_req_t mem_req;
  entry_t   rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  assign s_axis_tready_o = idle && !m_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.kind             <= s_axis_tuser_i;
      cmd_q.now              <= s_axis_tdata_i[62:0];
      cmd_q.ent.deadline     <= s_axis_tdata_i[125:63];
      cmd_q.ent.msg_id       <= s_axis_tdata_i[157:126];
      cmd_q.ent.target       <= s_axis_tdata_i[173:158];
      cmd_q.ent.obj_key      <= s_axis_tdata_i[205:174];
      cmd_q.ent.callback_key <= s_axis_tdata_i[237:206];
      cmd_q.ent.token        <= s_axis_tdata_i[301:238];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign rdata = entry_t'(rdata_raw);

  dmq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(rdata_raw)
  );

  dmq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .cmd_i    (cmd_q),
    .rdata_i  (rdata),
    .mem_req_o(mem_req),
    .idle_o   (idle),
    .done_o   (done),
    .res_o    (res)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, res.wake_delay, res.ent.deadline, res.ent.token,
                            res.ent.callback_key, res.ent.obj_key, res.ent.target,
                            res.ent.msg_id};
  assign m_axis_tuser_o  = {res.wake_request, res.status};

  `DMQ_ASSERT(a_no_overrun, done |-> !m_valid_q, "result produced while output full")

endmodule
